// ===== hdl/bssi_pkg.sv =====
// ----------------------------------------------------------------------------
// bssi_pkg
// Shared types and constants of the bit-sliced signature index.
// ----------------------------------------------------------------------------
`default_nettype none

package bssi_pkg;

  // fixed field widths
  localparam int unsigned HashW    = 32;
  localparam int unsigned DocW     = 6;
  localparam int unsigned RowBitsW = 4;

  // row_bits value after reset
  localparam logic [RowBitsW-1:0] RowBitsReset = 4'd10;

  // command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  // input request
  typedef struct packed {
    logic             cmd;
    logic [HashW-1:0] row_hash;
    logic [DocW-1:0]  doc_index;
    logic             last_term;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [DocW-1:0] match_doc;
    logic            match_found;
    logic            last;
  } out_req_t;

endpackage

`default_nettype wire

// ===== hdl/bit_sliced_signature_index.sv =====
// ----------------------------------------------------------------------------
// bit_sliced_signature_index
// Bit-sliced Bloom signature store with insert and multi-term query.
// ----------------------------------------------------------------------------
// After reset the block clears the slice memory, one row a cycle, and stalls
// its input meanwhile (configuration writes are taken at any time). An insert
// or a query term that is not the last takes one synchronous read of the
// slice memory, then one write-back or AND into the query mask. The last term
// of a query does the read and the AND, then enters an emit phase with one
// result per cycle (at least one, the no-match result) while the output is not
// stalled, each result picked by a lowest-set-bit search over the hit mask and
// held in an output register; output stall stretches that phase. Only one
// request is in work at a time.
`default_nettype none

module bit_sliced_signature_index #(
  parameter int unsigned ROWS         = 1024,
  parameter int unsigned DOC_CAPACITY = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [bssi_pkg::RowBitsW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire bssi_pkg::in_req_t          in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output bssi_pkg::out_req_t              out_req_o
);
  import bssi_pkg::*;

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [DOC_CAPACITY-1:0] AllOnes = '1;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [RowBitsW-1:0]     row_bits_q;
  logic [RowW-1:0]         clr_q;
  logic [RowW-1:0]         row_q;
  logic [RowW-1:0]         in_row;
  in_req_t                 req_q;
  logic [DOC_CAPACITY-1:0] rd_q;
  logic [DOC_CAPACITY-1:0] mask_q;
  logic [DOC_CAPACITY-1:0] hits_q;
  logic [DOC_CAPACITY-1:0] hits_rest;
  logic [DOC_CAPACITY-1:0] doc_bit;
  logic [DOC_CAPACITY-1:0] slice_mem [ROWS];
  logic                    out_valid_q;
  out_req_t                out_q;
  logic                    accept;
  logic                    out_free;
  logic                    mem_we;
  logic [RowW-1:0]         mem_waddr;
  logic [DOC_CAPACITY-1:0] mem_wdata;
  logic [DocW-1:0]         low_idx;
  logic [31:0]             span_mask;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // row select: hash masked by rows in use and by the store depth
  assign span_mask = (32'd1 << row_bits_q) - 32'd1;
  assign in_row    = RowW'(in_req_i.row_hash & span_mask & 32'(ROWS - 1));

  // document bit for an insert, empty when beyond capacity
  always_comb begin
    doc_bit = '0;
    if (32'(req_q.doc_index) < DOC_CAPACITY) begin
      doc_bit[req_q.doc_index[$clog2(DOC_CAPACITY)-1:0]] = 1'b1;
    end
  end

  // lowest set bit of the hit mask
  always_comb begin
    low_idx = '0;
    for (int d = DOC_CAPACITY - 1; d >= 0; d--) begin
      if (hits_q[d]) begin
        low_idx = DocW'(d);
      end
    end
  end
  assign hits_rest = hits_q & (hits_q - 1'b1);

  // memory write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = rd_q | doc_bit;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_UPDATE && req_q.cmd == CmdInsert) begin
      mem_we = 1'b1;
    end
  end

  // slice memory, read on accept, written on an insert's update or on clear
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slice_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= slice_mem[in_row];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
      row_q <= in_row;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == RowW'(ROWS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (req_q.cmd == CmdQuery && req_q.last_term) state_d = ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free && (hits_q == '0 || hits_rest == '0)) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      row_bits_q  <= RowBitsReset;
      mask_q      <= AllOnes;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        row_bits_q <= cfg_data_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      // query term folds into the mask
      if (state_q == ST_UPDATE && req_q.cmd == CmdQuery) begin
        if (req_q.last_term) begin
          hits_q <= mask_q & rd_q;
          mask_q <= AllOnes;
        end else begin
          mask_q <= mask_q & rd_q;
        end
      end
      // output register
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        hits_q      <= hits_rest;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      if (hits_q == '0) begin
        out_q.match_doc   <= '0;
        out_q.match_found <= 1'b0;
        out_q.last        <= 1'b1;
      end else begin
        out_q.match_doc   <= low_idx;
        out_q.match_found <= 1'b1;
        out_q.last        <= (hits_rest == '0);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bssi_checker.sv =====
// ----------------------------------------------------------------------------
// bssi_checker
// Port-level checks of the bit-sliced signature index, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bssi_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire bssi_pkg::out_req_t  out_req_o
);
  import bssi_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted request keeps the input stalled for its update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during update");

  // results of one query follow back to back in ascending order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_req_o.last |=>
      out_valid_o && out_req_o.match_doc > $past(out_req_o.match_doc))
    else $error("match results out of order or gapped");

  // a no-match result is alone and zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.match_found |->
      out_req_o.last && out_req_o.match_doc == '0)
    else $error("malformed no-match result");

endmodule

bind bit_sliced_signature_index bssi_checker u_bssi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire

// ===== tb/bit_sliced_signature_index_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_sliced_signature_index_tb
// Self-checking bench for the signature index: drives insert and query
// requests, predicts the match list of every finished query and checks each
// result request in order, under random idling, a long output hold-off and
// several row_bits settings.
// ----------------------------------------------------------------------------
module bit_sliced_signature_index_tb;
  import bssi_pkg::*;

  localparam int unsigned StoreRows  = 1024;
  localparam int unsigned RowIdxW    = $clog2(StoreRows);
  localparam int unsigned DocSlots   = 64;
  localparam int unsigned PoolSize   = 8;
  localparam int unsigned PoolIdxW   = $clog2(PoolSize);
  localparam int unsigned SettleCyc  = 16;
  localparam int unsigned HoldCyc    = 400;
  localparam int unsigned CycleLimit = 200000;

  // scoreboard: signature store mirror plus queue of expected match results
  class match_scoreboard;
    logic [DocSlots-1:0] slices[StoreRows];
    logic [DocSlots-1:0] run_mask;
    logic [RowBitsW-1:0] row_bits;
    out_req_t            match_q[$];
    int                  n_inserts, n_terms, n_results, n_nomatch, n_settings, n_errors;

    function new();
      foreach (slices[i]) slices[i] = '0;
      run_mask = '1;
      row_bits = RowBitsReset;
    endfunction

    function void set_row_bits(logic [RowBitsW-1:0] v);
      row_bits = v;
      n_settings++;
    endfunction

    // hash reduced to the rows in use, and never past the store
    function logic [RowIdxW-1:0] row_of(logic [HashW-1:0] h);
      logic [31:0] span;
      span = (32'd1 << row_bits) - 32'd1;
      return RowIdxW'(h & span & 32'(StoreRows - 1));
    endfunction

    function void note_request(in_req_t r);
      logic [RowIdxW-1:0]  row;
      logic [DocSlots-1:0] hits;
      out_req_t            res;
      row = row_of(r.row_hash);
      if (r.cmd == CmdInsert) begin
        slices[row][r.doc_index] = 1'b1;
        n_inserts++;
        return;
      end
      n_terms++;
      run_mask &= slices[row];
      if (!r.last_term) return;
      hits     = run_mask;
      run_mask = '1;
      // empty mask gives a single no-match result
      if (hits == '0) begin
        res.match_doc   = '0;
        res.match_found = 1'b0;
        res.last        = 1'b1;
        match_q.push_back(res);
        n_nomatch++;
        return;
      end
      // ascending document order, last flag on the highest one
      for (int d = 0; d < DocSlots; d++) begin
        if (hits[d]) begin
          res.match_doc   = DocW'(d);
          res.match_found = 1'b1;
          res.last        = ((hits >> (d + 1)) == '0);
          match_q.push_back(res);
        end
      end
    endfunction

    function void check_result(out_req_t r);
      out_req_t exp_res;
      if (match_q.size() == 0) begin
        $error("unexpected result: match_doc %0d match_found %0d last %0d",
               r.match_doc, r.match_found, r.last);
        n_errors++;
        return;
      end
      exp_res = match_q.pop_front();
      n_results++;
      if (r.match_doc !== exp_res.match_doc) begin
        $error("match_doc: expected %0d, got %0d", exp_res.match_doc, r.match_doc);
        n_errors++;
      end
      if (r.match_found !== exp_res.match_found) begin
        $error("match_found: expected %0d, got %0d", exp_res.match_found, r.match_found);
        n_errors++;
      end
      if (r.last !== exp_res.last) begin
        $error("last: expected %0d, got %0d", exp_res.last, r.last);
        n_errors++;
      end
    endfunction

    function void flag_leftovers();
      foreach (match_q[i]) begin
        $error("missing result: match_doc %0d match_found %0d last %0d",
               match_q[i].match_doc, match_q[i].match_found, match_q[i].last);
        n_errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [RowBitsW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_req_t             in_req_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_req_t            out_req_o;

  match_scoreboard     sb;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  bit                  hold_pending = 1'b0;
  int unsigned         cycle_count = 0;
  logic [HashW-1:0]    term_pool[PoolSize];

  bit_sliced_signature_index u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // monitor: results are checked before the same edge's request is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_req_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
    end
  end

  // receiver: random stall, or a long hold-off when one is pending
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCyc) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic in_req_t term_req(logic cmd, logic [HashW-1:0] hash,
                                       logic [DocW-1:0] doc, logic last_term);
    in_req_t r;
    r.cmd       = cmd;
    r.row_hash  = hash;
    r.doc_index = doc;
    r.last_term = last_term;
    return r;
  endfunction

  // offer one request and hold it until taken
  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain all expected results and let the block go back to idle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.match_q.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_row_bits(input logic [RowBitsW-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_row_bits(v);
  endtask

  task automatic refill_pool();
    foreach (term_pool[i]) term_pool[i] = $urandom;
  endtask

  // random traffic: mostly inserts and queries over a small term pool
  task automatic run_random(input int n_items);
    int sent;
    int pick;
    int n_q;
    int t;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_req(term_req(CmdInsert, term_pool[PoolIdxW'($urandom_range(PoolSize - 1))],
                          DocW'($urandom_range(63)), 1'($urandom_range(1))));
        sent++;
      end else if (pick < 85) begin
        n_q = $urandom_range(1, 3);
        for (t = 0; t < n_q; t++) begin
          send_req(term_req(CmdQuery, term_pool[PoolIdxW'($urandom_range(PoolSize - 1))],
                            DocW'($urandom_range(63)), (t == n_q - 1)));
          sent++;
        end
      end else begin
        // noise: any field value, broken queries included
        send_req(term_req(1'($urandom_range(1)), $urandom, DocW'($urandom_range(63)),
                          1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  initial begin
    int d;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and row mapping corners at reset row_bits
    send_req(term_req(CmdInsert, 32'hFFFF_FFFF, 6'd63, 1'b1));
    send_req(term_req(CmdInsert, 32'h0000_0000, 6'd0, 1'b0));
    send_req(term_req(CmdInsert, 32'h0000_0400, 6'd5, 1'b0));
    send_req(term_req(CmdQuery, 32'h0000_0000, 6'd0, 1'b1));
    send_req(term_req(CmdQuery, 32'hFFFF_FFFF, 6'd17, 1'b1));
    send_req(term_req(CmdQuery, 32'h0001_2345, 6'd63, 1'b1));
    send_req(term_req(CmdQuery, 32'h0000_0000, 6'd0, 1'b0));
    send_req(term_req(CmdQuery, 32'h0000_0400, 6'd0, 1'b1));
    send_req(term_req(CmdQuery, 32'h0000_0000, 6'd0, 1'b0));
    send_req(term_req(CmdQuery, 32'hFFFF_FFFF, 6'd0, 1'b1));
    send_req(term_req(CmdQuery, 32'hFFFF_FFFF, 6'd0, 1'b1));

    // zero row bits: everything lands in row 0
    write_row_bits(4'd0);
    send_req(term_req(CmdQuery, 32'hDEAD_BEEF, 6'd0, 1'b1));
    send_req(term_req(CmdInsert, 32'hABCD_EF01, 6'd33, 1'b0));
    send_req(term_req(CmdQuery, 32'h8000_0000, 6'd0, 1'b1));

    // row bits past the store size behave as full width
    write_row_bits(4'd15);
    send_req(term_req(CmdQuery, 32'hFFFF_FFFF, 6'd0, 1'b1));
    send_req(term_req(CmdQuery, 32'h0000_0400, 6'd0, 1'b1));

    // one row bit
    write_row_bits(4'd1);
    send_req(term_req(CmdQuery, 32'h0000_0003, 6'd0, 1'b1));
    send_req(term_req(CmdInsert, 32'h0000_0001, 6'd1, 1'b1));
    send_req(term_req(CmdQuery, 32'hFFFF_FFFF, 6'd0, 1'b1));
    send_req(term_req(CmdQuery, 32'h0000_0002, 6'd0, 1'b0));
    send_req(term_req(CmdQuery, 32'h0000_0005, 6'd0, 1'b1));

    // random, sender idles lightly and receiver heavily
    write_row_bits(4'd4);
    refill_pool();
    send_idle_pct = 21;
    recv_idle_pct = 81;
    run_random(30);

    // random, the other way round
    write_row_bits(4'd10);
    refill_pool();
    send_idle_pct = 81;
    recv_idle_pct = 21;
    run_random(30);

    // no idling; fill one row with every document and hold the output off
    write_row_bits(4'd15);
    refill_pool();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (d = 0; d < DocSlots; d++) begin
      send_req(term_req(CmdInsert, term_pool[0], DocW'(d), 1'b0));
    end
    hold_pending = 1'b1;
    send_req(term_req(CmdQuery, term_pool[0], 6'd0, 1'b1));
    run_random(24);

    // drain and finish
    wait_idle();
    sb.flag_leftovers();
    $display("covered %0d inserts and %0d query terms, %0d results checked (%0d no-match)",
             sb.n_inserts, sb.n_terms, sb.n_results, sb.n_nomatch);
    $display("row_bits settings written: %0d, mismatches: %0d", sb.n_settings, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
